// ----- design/nmea_rx_pkg.sv -----
// shared types and character codes for the nmea sentence receiver
`default_nettype none

package nmea_rx_pkg;

    // fixed widths of the result fields
    localparam int CHAR_W  = 8;
    localparam int FIELD_W = 5;
    localparam int INDEX_W = 4;
    localparam int TDATA_W = 32;

    // special characters
    localparam logic [CHAR_W-1:0] CH_START   = 8'h24;  // '$'
    localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;  // '*'
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;  // ','
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VOID    = 8'h56;  // 'V'
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;

    // field whose first character flags a void fix
    localparam logic [FIELD_W-1:0] VOID_FIELD = 5'd2;

    // one result beat
    typedef struct packed {
        logic               status;
        logic [CHAR_W-1:0]  data_char;
        logic [FIELD_W-1:0] field_index;
        logic [INDEX_W-1:0] char_index;
        logic               char_stored;
        logic               field_end;
        logic               sentence_end;
        logic [FIELD_W-1:0] field_count;
        logic               checksum_ok;
        logic               status_void;
        logic               overflow;
    } nmea_rx_result_t;

endpackage

`default_nettype wire

// ----- design/nmea_rx_parse.sv -----
// input register, sentence state and per-byte result logic
`default_nettype none

module nmea_rx_parse
    import nmea_rx_pkg::*;
#(
    parameter int MAX_FIELDS      = 20,
    parameter int MAX_FIELD_CHARS = 15
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CHAR_W-1:0] in_byte,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output nmea_rx_result_t        res
);

    localparam logic [FIELD_W-1:0] MAX_F     = FIELD_W'(MAX_FIELDS);
    localparam logic [FIELD_W-1:0] MAX_F_M1  = FIELD_W'(MAX_FIELDS - 1);
    localparam logic [INDEX_W-1:0] MAX_C     = INDEX_W'(MAX_FIELD_CHARS);

    typedef struct packed {
        logic               in_sentence;
        logic               summing;
        logic               taking_check_digits;
        logic [CHAR_W-1:0]  running_xor;
        logic [FIELD_W-1:0] current_field;
        logic [INDEX_W-1:0] current_char;
        logic [1:0]         check_digit_count;
        logic [2*CHAR_W-1:0] check_digits;
        logic               void_seen;
        logic               overflow_seen;
    } parse_state_t;

    // hex digit decode: {valid, value}
    function automatic logic [4:0] hex_val(input logic [CHAR_W-1:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            r = {1'b1, 4'(c - CH_DIGIT_0)};
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            r = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            r = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
        end
        return r;
    endfunction

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_byte_reg;
    logic              consume;
    parse_state_t      st_reg;
    parse_state_t      st_next;
    nmea_rx_result_t   res_next;
    logic [4:0]        hi_dec;
    logic [4:0]        lo_dec;

    assign consume   = in_valid_reg && res_ready;
    assign in_ready  = !in_valid_reg || res_ready;
    assign res_valid = in_valid_reg;
    assign res       = res_next;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            in_byte_reg <= in_byte;
        end
    end

    assign hi_dec = hex_val(st_reg.check_digits[2*CHAR_W-1:CHAR_W]);
    assign lo_dec = hex_val(st_reg.check_digits[CHAR_W-1:0]);

    // per-byte state update and result
    always_comb begin
        st_next           = st_reg;
        res_next          = '0;
        res_next.data_char = in_byte_reg;
        if (in_byte_reg == CH_START) begin
            st_next             = '0;
            st_next.in_sentence = 1'b1;
            st_next.summing     = 1'b1;
        end else if (!st_reg.in_sentence) begin
            res_next.status = 1'b1;
        end else if (in_byte_reg == CH_CR || in_byte_reg == CH_LF) begin
            res_next.field_index  = st_reg.current_field;
            res_next.char_index   = st_reg.current_char;
            res_next.field_end    = 1'b1;
            res_next.sentence_end = 1'b1;
            res_next.field_count  = (st_reg.current_field >= MAX_F) ? MAX_F
                                  : st_reg.current_field + 1'b1;
            res_next.checksum_ok  = st_reg.check_digit_count[1] && hi_dec[4] && lo_dec[4]
                                  && ({hi_dec[3:0], lo_dec[3:0]} == st_reg.running_xor);
            res_next.status_void  = st_reg.void_seen;
            res_next.overflow     = st_reg.overflow_seen;
            st_next.in_sentence         = 1'b0;
            st_next.summing             = 1'b0;
            st_next.taking_check_digits = 1'b0;
        end else begin
            // check digit capture, first two bytes after the star
            if (st_reg.taking_check_digits && !st_reg.check_digit_count[1]) begin
                if (st_reg.check_digit_count == 2'd0) begin
                    st_next.check_digits = {in_byte_reg, {CHAR_W{1'b0}}};
                end else begin
                    st_next.check_digits = {st_reg.check_digits[2*CHAR_W-1:CHAR_W],
                                            in_byte_reg};
                end
                st_next.check_digit_count = st_reg.check_digit_count + 2'd1;
            end
            // running checksum up to the first star
            if (st_reg.summing && in_byte_reg == CH_STAR) begin
                st_next.summing             = 1'b0;
                st_next.taking_check_digits = 1'b1;
            end else if (st_reg.summing) begin
                st_next.running_xor = st_reg.running_xor ^ in_byte_reg;
            end

            res_next.field_index = st_reg.current_field;
            res_next.char_index  = st_reg.current_char;

            if (in_byte_reg == CH_COMMA || in_byte_reg == CH_STAR) begin
                // field delimiter
                res_next.field_end = 1'b1;
                if (st_reg.current_field >= MAX_F_M1) begin
                    st_next.overflow_seen = 1'b1;
                    st_next.current_field = MAX_F;
                end else begin
                    st_next.current_field = st_reg.current_field + 1'b1;
                end
                st_next.current_char = '0;
            end else begin
                // field content
                if (st_reg.current_field < MAX_F && st_reg.current_char < MAX_C) begin
                    res_next.char_stored = 1'b1;
                    if (st_reg.current_field == VOID_FIELD && st_reg.current_char == '0
                        && in_byte_reg == CH_VOID) begin
                        st_next.void_seen = 1'b1;
                    end
                end else begin
                    st_next.overflow_seen = 1'b1;
                end
                if (st_reg.current_char < MAX_C) begin
                    st_next.current_char = st_reg.current_char + 1'b1;
                end
            end
            res_next.overflow = st_next.overflow_seen;
        end
    end

    // sentence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (consume) begin
            st_reg <= st_next;
        end
    end

    // a line end inside a sentence always closes it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && st_reg.in_sentence && (in_byte_reg == CH_CR || in_byte_reg == CH_LF))
        |=> !st_reg.in_sentence)
        else $error("sentence still open after line end");

    // indices stay within their bounds
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.current_field <= MAX_F && st_reg.current_char <= MAX_C)
        else $error("field or char index past bound");

    // checksum and check digit capture never run together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(st_reg.summing && st_reg.taking_check_digits))
        else $error("summing while taking check digits");

endmodule

`default_nettype wire

// ----- design/nmea_rx_skid.sv -----
// result register with skid stage, keeps upstream ready registered
`default_nettype none

module nmea_rx_skid
    import nmea_rx_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wire nmea_rx_result_t up_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output nmea_rx_result_t out_data
);

    logic            main_valid_reg;
    logic            skid_valid_reg;
    nmea_rx_result_t main_reg;
    nmea_rx_result_t skid_reg;
    logic            up_fire;
    logic            out_fire;

    assign up_ready  = !skid_valid_reg;
    assign up_fire   = up_valid && !skid_valid_reg;
    assign out_fire  = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (up_fire) begin
            if (!main_valid_reg || out_ready) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (up_fire) begin
            if (!main_valid_reg || out_ready) begin
                main_reg <= up_data;
            end else begin
                skid_reg <= up_data;
            end
        end else if (out_fire && skid_valid_reg) begin
            main_reg <= skid_reg;
        end
    end

    // skid only fills behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds a beat with empty output");

    // a stalled beat moves into the skid, not over the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && !out_ready && up_fire) |=> skid_valid_reg)
        else $error("beat lost on stalled output");

endmodule

`default_nettype wire

// ----- design/nmea_sentence_receiver.sv -----
// path: an accepted input beat passes the input register, then the result register, to its result on m_axis
// throughput: one byte per cycle while m_axis_tready stays high, one result beat per input beat
// the state update for a byte is a single pass of logic behind the input register
// a two-entry output stage keeps s_axis_tready free of a path from m_axis_tready
// reset: aresetn low clears all sentence state and both channels empty
`default_nettype none

module nmea_sentence_receiver
    import nmea_rx_pkg::*;
#(
    parameter int MAX_FIELDS      = 20,
    parameter int MAX_FIELD_CHARS = 15
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [CHAR_W-1:0]  s_axis_tdata,   // rx_byte
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // data_char[7:0], field_index[12:8], char_index[16:13], char_stored[17],
    // field_end[18], field_count[23:19], checksum_ok[24], status_void[25],
    // overflow[26], zero[31:27]
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic                    m_axis_tuser,   // status
    output logic                    m_axis_tlast    // sentence_end
);

    logic            res_valid;
    logic            res_ready;
    nmea_rx_result_t res;
    nmea_rx_result_t out;

    // byte parsing
    nmea_rx_parse #(
        .MAX_FIELDS      (MAX_FIELDS),
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result register
    nmea_rx_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .up_valid  (res_valid),
        .up_ready  (res_ready),
        .up_data   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out)
    );

    // pack the result beat
    assign m_axis_tdata = {5'd0, out.overflow, out.status_void, out.checksum_ok,
                           out.field_count, out.field_end, out.char_stored,
                           out.char_index, out.field_index, out.data_char};
    assign m_axis_tuser = out.status;
    assign m_axis_tlast = out.sentence_end;

endmodule

`default_nettype wire
